// ----- sv/ansi_escape_stripper_core_defines.svh -----
// ----------------------------------------------------------------------------
// ansi escape stripper assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_STRIPPER_CORE_DEFINES_SVH
`define ANSI_ESCAPE_STRIPPER_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define AES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live through reset
`define AES_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// shared types and byte codes for the ansi escape stripper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1a;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_INTHI = 8'h2f;
  localparam logic [7:0] CH_FINLO = 8'h30;
  localparam logic [7:0] CH_CSIFL = 8'h40;
  localparam logic [7:0] CH_FINHI = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_DCS   = 8'h50;
  localparam logic [7:0] CH_CSI   = 8'h5b;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_OSC   = 8'h5d;
  localparam logic [7:0] CH_PM    = 8'h5e;
  localparam logic [7:0] CH_APC   = 8'h5f;

  typedef enum logic [7:0] {
    ST_NORMAL    = 8'b0000_0001,
    ST_ESC       = 8'b0000_0010,
    ST_CSI       = 8'b0000_0100,
    ST_OSC       = 8'b0000_1000,
    ST_OSC_ESC   = 8'b0001_0000,
    ST_STR       = 8'b0010_0000,
    ST_STR_ESC   = 8'b0100_0000,
    ST_ESC_INTER = 8'b1000_0000
  } parse_state_t;

  typedef struct packed {
    parse_state_t next_state;
    logic         keep;
  } step_res_t;

endpackage

`default_nettype wire

// ----- sv/ansi_escape_stripper_core.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_stripper_core
// removes ecma-48 escape sequences and stray controls from a byte stream
// ----------------------------------------------------------------------------
// usage
//   item channel: data_byte and chunk_end with item_valid / item_stall; a
//   transaction completes on a clock edge with item_valid high, item_stall low
//   result channel: keep, out_byte, chunk_end_out with result_valid /
//   result_stall; exactly one result per input byte, in order
//   out_byte is zero when keep is low; chunk_end_out echoes chunk_end
//   pipeline: a byte passes through the input register, then the result
//   register, before result_valid rises; throughput one byte per cycle while
//   result_stall is low, set by the single parser state register updated once
//   per byte
//   stall: the result register holds while result_stall is high; an empty
//   input register still takes one more byte, then item_stall rises
//   reset: synchronous, clears both valid flags and returns the parser to
//   normal text state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ansi_escape_stripper_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       chunk_end,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            keep,
  output logic [7:0]      out_byte,
  output logic            chunk_end_out
);
  import aes_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_chunk_end;
  parse_state_t state;
  step_res_t    step;
  logic         item_accept;
  logic         s1_advance;

  assign item_stall  = s1_valid && result_valid && result_stall;
  assign item_accept = item_valid && !item_stall;
  assign s1_advance  = s1_valid && !(result_valid && result_stall);

  aes_step u_step (
    .state (state),
    .data  (s1_byte),
    .res   (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      state        <= ST_NORMAL;
    end else begin
      s1_valid     <= item_accept || (s1_valid && !s1_advance);
      result_valid <= s1_advance || (result_valid && result_stall);
      if (s1_advance) begin
        state <= step.next_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_byte      <= data_byte;
      s1_chunk_end <= chunk_end;
    end
    if (s1_advance) begin
      keep          <= step.keep;
      out_byte      <= step.keep ? s1_byte : 8'h00;
      chunk_end_out <= s1_chunk_end;
    end
  end

endmodule

`default_nettype wire

// ----- sv/aes_step.sv -----
// ----------------------------------------------------------------------------
// aes_step
// one-byte parser step: next state and keep flag, reprocessing folded in
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aes_step (
  input  wire aes_pkg::parse_state_t state,
  input  wire logic [7:0]            data,
  output aes_pkg::step_res_t         res
);
  import aes_pkg::*;

  logic abort_byte;
  logic passes;
  logic in_final;
  logic in_inter;
  logic in_csi_final;

  assign abort_byte   = (data == CH_LF) || (data == CH_CAN) || (data == CH_SUB);
  assign passes       = (data == CH_TAB) || (data == CH_LF) ||
                        ((data >= CH_SPACE) && (data != CH_DEL));
  assign in_final     = (data >= CH_FINLO) && (data <= CH_FINHI);
  assign in_inter     = (data >= CH_SPACE) && (data <= CH_INTHI);
  assign in_csi_final = (data >= CH_CSIFL) && (data <= CH_FINHI);

  always_comb begin
    res.next_state = state;
    res.keep       = 1'b0;
    case (state)
      ST_NORMAL: begin
        if (data == CH_ESC) begin
          res.next_state = ST_ESC;
        end else begin
          res.keep = passes;
        end
      end
      ST_ESC: begin
        if (data == CH_CSI) begin
          res.next_state = ST_CSI;
        end else if (data == CH_OSC) begin
          res.next_state = ST_OSC;
        end else if ((data == CH_DCS) || (data == CH_PM) || (data == CH_APC)) begin
          res.next_state = ST_STR;
        end else if (in_inter) begin
          res.next_state = ST_ESC_INTER;
        end else if (in_final) begin
          res.next_state = ST_NORMAL;
        end else if (data == CH_ESC) begin
          // malformed: escape dropped, new escape opens
          res.next_state = ST_ESC;
        end else begin
          res.next_state = ST_NORMAL;
          res.keep       = passes;
        end
      end
      ST_CSI: begin
        if (abort_byte) begin
          res.next_state = ST_NORMAL;
          res.keep       = (data == CH_LF);
        end else if (in_csi_final) begin
          res.next_state = ST_NORMAL;
        end
      end
      ST_OSC, ST_OSC_ESC: begin
        if ((state == ST_OSC_ESC) && (data == CH_BSL)) begin
          res.next_state = ST_NORMAL;
        end else if (abort_byte) begin
          res.next_state = ST_NORMAL;
          res.keep       = (data == CH_LF);
        end else if (data == CH_BEL) begin
          res.next_state = ST_NORMAL;
        end else if (data == CH_ESC) begin
          res.next_state = ST_OSC_ESC;
        end else begin
          res.next_state = ST_OSC;
        end
      end
      ST_STR, ST_STR_ESC: begin
        if ((state == ST_STR_ESC) && (data == CH_BSL)) begin
          res.next_state = ST_NORMAL;
        end else if (abort_byte) begin
          res.next_state = ST_NORMAL;
          res.keep       = (data == CH_LF);
        end else if (data == CH_ESC) begin
          res.next_state = ST_STR_ESC;
        end else begin
          res.next_state = ST_STR;
        end
      end
      ST_ESC_INTER: begin
        if (abort_byte) begin
          res.next_state = ST_NORMAL;
          res.keep       = (data == CH_LF);
        end else if (in_final) begin
          res.next_state = ST_NORMAL;
        end
      end
      default: begin
        res.next_state = ST_NORMAL;
        res.keep       = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/aes_checker.sv -----
// ----------------------------------------------------------------------------
// aes_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ansi_escape_stripper_core_defines.svh"

module aes_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic       keep,
  input wire logic [7:0] out_byte,
  input wire logic       chunk_end_out
);
  import aes_pkg::*;

  `AES_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(keep) && $stable(out_byte) && $stable(chunk_end_out), "stalled result changed")
  `AES_ASSERT_NOW(a_drop_zero, result_valid && !keep, out_byte == 8'h00, "dropped byte not zero")
  `AES_ASSERT_NOW(a_kept_ok, result_valid && keep, out_byte == CH_TAB || out_byte == CH_LF || (out_byte >= CH_SPACE && out_byte != CH_DEL), "control byte emitted")
  `AES_ASSERT_RST(a_reset, rst, !result_valid, "result valid after reset")

endmodule

bind ansi_escape_stripper_core aes_checker u_aes_checker (.*);

`default_nettype wire
